FILE: hdl/fba_pkg.sv
// Shared types and constants of the frame bitmap allocator.
package fba_pkg;

  localparam int CfgW      = 13;  // frame_limit register width
  localparam int FrameW    = 12;  // frame number width
  localparam int WordBits  = 32;  // frames per bitmap word
  localparam int BitIdxW   = 5;   // bit index inside a bitmap word
  localparam int CntW      = CfgW - BitIdxW;  // word counter, holds a full word count
  localparam int FrameWordsMax = 1 << (FrameW - BitIdxW);  // words reachable by 12-bit frames
  localparam int StatusW   = 3;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 16;

  localparam logic [StatusW-1:0] ST_ALLOC  = 3'd0;
  localparam logic [StatusW-1:0] ST_MAPPED = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 3'd2;
  localparam logic [StatusW-1:0] ST_FREED  = 3'd3;
  localparam logic [StatusW-1:0] ST_NONE   = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    RK_ALLOC,
    RK_MAPPED,
    RK_FULL,
    RK_FREED,
    RK_NONE
  } res_kind_e;

  typedef struct packed {
    logic      req_ld;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      clr_we;
    logic      scan_rd;
    logic      hit_we;
    logic      free_rd;
    logic      free_we;
    logic      out_ld;
    res_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic in_pf_zero;
    logic in_pf_ok;
    logic clr_last;
    logic issue_done;
    logic rvld;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/fba_ctrl.sv
// Controller state machine of the frame bitmap allocator.
module fba_ctrl import fba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e    state_q, state_d;
  res_kind_e kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kind_q  <= RK_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Next state and the kind of result to report.
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          if (sts_i.in_alloc) begin
            if (!sts_i.in_pf_zero) begin
              kind_d  = RK_MAPPED;
              state_d = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end else if (sts_i.in_pf_zero || !sts_i.in_pf_ok) begin
            kind_d  = RK_NONE;
            state_d = S_RESP;
          end else begin
            state_d = S_FREE_RD;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          kind_d  = RK_ALLOC;
          state_d = S_RESP;
        end else if (sts_i.issue_done && !sts_i.rvld) begin
          kind_d  = RK_FULL;
          state_d = S_RESP;
        end
      end
      S_FREE_RD: state_d = S_FREE_WR;
      S_FREE_WR: begin
        kind_d  = RK_FREED;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    s_ready_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.req_ld  = s_valid_i;
        cmd_o.cnt_clr = 1'b1;
      end
      S_SCAN: begin
        cmd_o.hit_we  = sts_i.hit;
        cmd_o.scan_rd = !sts_i.issue_done && !sts_i.hit;
        cmd_o.cnt_inc = !sts_i.issue_done && !sts_i.hit;
      end
      S_FREE_RD: cmd_o.free_rd = 1'b1;
      S_FREE_WR: cmd_o.free_we = 1'b1;
      S_RESP:    cmd_o.out_ld  = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hdl/fba_dpath.sv
// Datapath of the frame bitmap allocator: bitmap memory, scan counter and result register.
module fba_dpath import fba_pkg::*; #(
  parameter int MAX_FRAMES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_cmd_i,
  input  logic [FrameW-1:0]   in_page_frame_i,
  input  logic                in_kernel_i,
  input  logic                in_writable_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [FrameW-1:0]   out_new_frame_o,
  output logic                out_present_o,
  output logic                out_rw_o,
  output logic                out_user_o,
  output logic [StatusW-1:0]  out_status_o,
  input  cmd_t                cmd_i,
  output sts_t                sts_o
);

  localparam int BmWords   = (MAX_FRAMES + WordBits - 1) / WordBits;
  localparam int MemWords  = (BmWords < FrameWordsMax) ? BmWords : FrameWordsMax;
  localparam int FullWords = MAX_FRAMES / WordBits;
  localparam int SearchMax = (FullWords < FrameWordsMax) ? FullWords : FrameWordsMax;
  localparam int AW        = (MemWords > 1) ? $clog2(MemWords) : 1;

  function automatic logic [BitIdxW-1:0] low_zero(input logic [WordBits-1:0] w);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!w[i]) idx = BitIdxW'(i);
    end
    return idx;
  endfunction

  logic [WordBits-1:0] mem [MemWords];

  logic [CfgW-1:0]     limit_q;
  logic                cmd_q;
  logic [FrameW-1:0]   pf_q;
  logic                kern_q, wr_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     n_words;
  logic [WordBits-1:0] rdata_q;
  logic [AW-1:0]       raddr_q;
  logic                rvld_q;
  logic [FrameW-1:0]   found_q;
  logic [BitIdxW-1:0]  zero_idx;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_addr;
  logic [WordBits-1:0] mem_wdata;
  logic [AW-1:0]       free_addr;

  logic                out_vld_q;
  logic [FrameW-1:0]   out_frame_q;
  logic                out_p_q, out_rw_q, out_us_q;
  logic [StatusW-1:0]  out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CfgW'(4096);
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_ld) begin
      cmd_q  <= in_cmd_i;
      pf_q   <= in_page_frame_i;
      kern_q <= in_kernel_i;
      wr_q   <= in_writable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr)      cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + CntW'(1);
      rvld_q <= cmd_i.scan_rd;
    end
  end

  // Whole words below the limit, clamped to the words that exist.
  assign n_words  = (limit_q[CfgW-1:BitIdxW] > CntW'(SearchMax))
                    ? CntW'(SearchMax) : limit_q[CfgW-1:BitIdxW];
  assign zero_idx = low_zero(rdata_q);
  assign free_addr = pf_q[BitIdxW +: AW];

  always_comb begin
    mem_we    = cmd_i.clr_we | cmd_i.hit_we | cmd_i.free_we;
    mem_re    = cmd_i.scan_rd | cmd_i.free_rd;
    mem_addr  = cnt_q[AW-1:0];
    mem_wdata = '0;
    if (cmd_i.hit_we) begin
      mem_addr  = raddr_q;
      mem_wdata = rdata_q | (WordBits'(1) << zero_idx);
    end else if (cmd_i.free_rd || cmd_i.free_we) begin
      mem_addr  = free_addr;
      mem_wdata = rdata_q & ~(WordBits'(1) << pf_q[BitIdxW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) raddr_q <= cnt_q[AW-1:0];
    if (cmd_i.hit_we)  found_q <= FrameW'({raddr_q, zero_idx});
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      case (cmd_i.kind)
        RK_ALLOC: begin
          out_frame_q <= found_q;
          out_p_q     <= 1'b1;
          out_rw_q    <= wr_q;
          out_us_q    <= ~kern_q;
          out_st_q    <= ST_ALLOC;
        end
        RK_MAPPED: begin
          out_frame_q <= pf_q;
          out_p_q     <= 1'b0;
          out_rw_q    <= 1'b0;
          out_us_q    <= 1'b0;
          out_st_q    <= ST_MAPPED;
        end
        RK_FULL: begin
          out_frame_q <= '0;
          out_p_q     <= 1'b0;
          out_rw_q    <= 1'b0;
          out_us_q    <= 1'b0;
          out_st_q    <= ST_FULL;
        end
        RK_FREED: begin
          out_frame_q <= '0;
          out_p_q     <= 1'b0;
          out_rw_q    <= 1'b0;
          out_us_q    <= 1'b0;
          out_st_q    <= ST_FREED;
        end
        RK_NONE: begin
          out_frame_q <= pf_q;
          out_p_q     <= 1'b0;
          out_rw_q    <= 1'b0;
          out_us_q    <= 1'b0;
          out_st_q    <= ST_NONE;
        end
        default: begin
          out_frame_q <= '0;
          out_p_q     <= 1'b0;
          out_rw_q    <= 1'b0;
          out_us_q    <= 1'b0;
          out_st_q    <= ST_NONE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_new_frame_o = out_frame_q;
  assign out_present_o   = out_p_q;
  assign out_rw_o        = out_rw_q;
  assign out_user_o      = out_us_q;
  assign out_status_o    = out_st_q;

  always_comb begin
    sts_o            = '0;
    sts_o.in_alloc   = (in_cmd_i == 1'b0);
    sts_o.in_pf_zero = (in_page_frame_i == '0);
    sts_o.in_pf_ok   = (32'(in_page_frame_i) < MAX_FRAMES);
    sts_o.clr_last   = (cnt_q == CntW'(MemWords - 1));
    sts_o.issue_done = (cnt_q >= n_words);
    sts_o.rvld       = rvld_q;
    sts_o.hit        = rvld_q && (rdata_q != '1) && (cmd_q == 1'b0);
    sts_o.out_free   = !out_vld_q || out_ready_i;
  end

endmodule

FILE: hdl/frame_bitmap_allocator_unit.sv
// Top level of the first-fit page frame allocator over a bitmap of used frames.
//
// This block hands out and takes back physical page frames. It keeps one bit per
// frame, 32 frames to a word, in a single-port bitmap memory. An allocate request
// (tuser 0) for a page entry that holds no frame walks the bitmap from word 0,
// one word read per cycle, takes the lowest clear frame below frame_limit (whole
// 32-frame words only), marks it used and returns it with present, writable and
// user flags; a full bitmap returns status 2. A free request (tuser 1) clears the
// frame's bit with a read-modify-write of its word. Requests that need no bitmap
// access go straight to the response step. After each result is loaded into the
// output register the controller returns to idle before it takes the next request.
// One request is in work at a time, and the next request is taken while the previous
// result still waits in the output register. After reset a clearing pass writes zero
// to each of the min(ceil(MAX_FRAMES/32), 128) bitmap words, one per cycle, and no
// request is accepted until it ends; configuration writes are the user's to make only
// while the block is idle, which the block itself leaves unchecked.
module frame_bitmap_allocator_unit import fba_pkg::*; #(
  parameter int MAX_FRAMES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: frame_limit.
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // Request stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [11:0] page_frame, [12] kernel_page,
                                              // [13] writable_page, [15:14] zero
  input  logic                s_axis_tuser,   // [0] cmd
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [11:0] new_frame, [12] present_flag,
                                              // [13] rw_flag, [14] user_flag, [15] zero
  output logic [StatusW-1:0]  m_axis_tuser    // [2:0] status
);

  cmd_t                cmd;
  sts_t                sts;
  logic [FrameW-1:0]   new_frame;
  logic                present_flag, rw_flag, user_flag;

  // The controller sequences clearing, scanning, freeing and result hand-off.
  fba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // The datapath owns the bitmap, the word counter and the output register.
  fba_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_cmd_i        (s_axis_tuser),
    .in_page_frame_i (s_axis_tdata[FrameW-1:0]),
    .in_kernel_i     (s_axis_tdata[FrameW]),
    .in_writable_i   (s_axis_tdata[FrameW+1]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_new_frame_o (new_frame),
    .out_present_o   (present_flag),
    .out_rw_o        (rw_flag),
    .out_user_o      (user_flag),
    .out_status_o    (m_axis_tuser),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  assign m_axis_tdata = {1'b0, user_flag, rw_flag, present_flag, new_frame};

  // Only one request is in work, so the request side closes right after an accept.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // A granted frame always carries the present flag.
  a_alloc_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ALLOC) |-> m_axis_tdata[FrameW])
    else $error("allocation result without present flag");

  // Results other than a grant carry no entry flags.
  a_flags_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_ALLOC) |-> (m_axis_tdata[FrameW+2:FrameW] == '0))
    else $error("flags set on a non-allocation result");

  // A result is only written while the controller is in its response step.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten before hand-off");

endmodule

FILE: bench/fba_checker.sv
// Shared request codes and result type of the allocator bench, and the checker that scores it.
`timescale 1ns / 1ps

package fba_tb_pkg;
  import fba_pkg::*;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } alloc_cmd_e;

  typedef struct packed {
    logic [FrameW-1:0]  frame;
    logic               present;
    logic               rw;
    logic               user;
    logic [StatusW-1:0] status;
  } frame_grant_t;
endpackage

module fba_checker import fba_pkg::*; import fba_tb_pkg::*; #(
  parameter int MaxFrames = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic [StatusW-1:0]  m_tuser_i,
  output int                  err_cnt_o,
  output int                  pending_o
);

  localparam int BmWords   = (MaxFrames + WordBits - 1) / WordBits;
  localparam int FullWords = MaxFrames / WordBits;

  logic [WordBits-1:0] frame_used [BmWords];
  logic [CfgW-1:0]     frame_limit_q;
  frame_grant_t        expected_grants [$];
  int                  mismatches;

  // First-fit search over whole words below the limit, clamped to the bitmap
  // and to frames that a 12-bit number can name.
  function automatic frame_grant_t predict_grant(alloc_cmd_e cmd, logic [FrameW-1:0] pf,
                                                 logic kern, logic wr);
    frame_grant_t g;
    int unsigned  words;
    bit           found;
    g = '0;
    found = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (pf != '0) begin
        g.frame  = pf;
        g.status = ST_MAPPED;
      end else begin
        words = frame_limit_q / WordBits;
        if (words > FullWords) words = FullWords;
        if (words > FrameWordsMax) words = FrameWordsMax;
        for (int w = 0; w < words && !found; w++) begin
          for (int b = 0; b < WordBits && !found; b++) begin
            if (!frame_used[w][b]) begin
              found         = 1'b1;
              frame_used[w][b] = 1'b1;
              g.frame       = FrameW'(w * WordBits + b);
              g.present     = 1'b1;
              g.rw          = wr;
              g.user        = ~kern;
              g.status      = ST_ALLOC;
            end
          end
        end
        if (!found) g.status = ST_FULL;
      end
    end else begin
      if (pf == '0) begin
        g.status = ST_NONE;
      end else if (pf >= MaxFrames) begin
        g.frame  = pf;
        g.status = ST_NONE;
      end else begin
        frame_used[pf / WordBits][pf % WordBits] = 1'b0;
        g.status = ST_FREED;
      end
    end
    return g;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_grant_t want;
    frame_grant_t got;
    if (!rst_ni) begin
      foreach (frame_used[i]) frame_used[i] = '0;
      frame_limit_q = CfgW'(4096);
      expected_grants.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) frame_limit_q = cfg_wdata_i;
      // Results are retired before new requests are predicted, so a request
      // taken at the same edge can never be matched against itself.
      if (m_tvalid_i && m_tready_i) begin
        got = '{frame: m_tdata_i[FrameW-1:0], present: m_tdata_i[12], rw: m_tdata_i[13],
                user: m_tdata_i[14], status: m_tuser_i};
        if (expected_grants.size() == 0) begin
          $error("result with no request waiting: frame %0d status %0d", got.frame,
                 got.status);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          check_field("new_frame", want.frame, got.frame);
          check_field("present_flag", want.present, got.present);
          check_field("rw_flag", want.rw, got.rw);
          check_field("user_flag", want.user, got.user);
          check_field("status", want.status, got.status);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_grants.push_back(predict_grant(alloc_cmd_e'(s_tuser_i),
                                                s_tdata_i[FrameW-1:0], s_tdata_i[12],
                                                s_tdata_i[13]));
      end
    end
    err_cnt_o <= mismatches;
    pending_o <= expected_grants.size();
  end

endmodule

FILE: bench/frame_bitmap_allocator_unit_tb.sv
// Testbench top of the frame bitmap allocator: request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module frame_bitmap_allocator_unit_tb;
  import fba_pkg::*;
  import fba_tb_pkg::*;

  // The receiver's long hold-off, the cycle budget with no request moving on
  // either side, and the settle time after the last result. The budget is many
  // times the slowest correct wait: a full scan, a random result stall, the long
  // hold-off or the clearing pass after reset.
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 200;
  localparam int PhaseItems  = 205;
  localparam int NumPhases   = 8;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  int err_cnt;
  int pending;
  int idle_cycles = 0;

  // Set by the stimulus side, read by the receiver process: a long hold-off is
  // wanted now, or all random gaps are switched off for this phase.
  bit long_hold = 1'b0;
  bit quiet     = 1'b0;

  // Frame limits of the random phases. The bitmap carries over from phase to
  // phase; the small limits fill it up and make allocations report a full
  // bitmap, 8191 exercises the clamp, and 31 leaves nothing to search.
  logic [CfgW-1:0] phase_limit [NumPhases] = '{13'd32, 13'd4096, 13'd64, 13'd8191,
                                               13'd96, 13'd31, 13'd2048, 13'd4096};

  frame_bitmap_allocator_unit #(
    .MAX_FRAMES(4096)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  fba_checker #(
    .MaxFrames(4096)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Reset is held at the start and never again.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The watchdog ends the run when neither stream has moved a request for
  // too long, which also catches results that never arrive.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("frame_bitmap_allocator_unit_tb: errors");
        $finish;
      end
    end
  end

  // Receiver: random stalls of the result stream, and on request one long
  // hold-off counted here, so that the block fills up and stops taking requests.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        stall_left = HoldCycles;
        long_hold  = 1'b0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
        stall_left = idle_gap();
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one request and holds it until the block takes it. Afterwards the
  // valid stays high when no gap follows, so back-to-back requests never see
  // valid dropped and raised within one step.
  task automatic send_request(alloc_cmd_e cmd, logic [FrameW-1:0] pf, logic kern, logic wr);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, wr, kern, pf};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = quiet ? 0 : idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every request has its result. It first lets
  // the checker count the last request taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // The limit register is only written once the block has drained.
  task automatic write_limit(logic [CfgW-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // A random request, mostly the well-formed kind that moves the bitmap:
  // allocations for empty entries and frees of low frames that first fit hands
  // out. The rest are entries that already hold a frame and frees of arbitrary
  // frame numbers, frame zero included.
  task automatic random_request(logic [CfgW-1:0] limit);
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(0, 99);
    span = (limit < 32 || limit > 256) ? 255 : limit - 1;
    if (r < 50) begin
      send_request(CMD_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (r < 58) begin
      send_request(CMD_ALLOC, FrameW'($urandom_range(1, 4095)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end else if (r < 90) begin
      send_request(CMD_FREE, FrameW'($urandom_range(0, span)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end else begin
      send_request(CMD_FREE, FrameW'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed part at the reset limit of 4096 frames. The first three
    // allocations hand out frames 0, 1 and 2 with three of the four flag combinations.
    send_request(CMD_ALLOC, '0, 1'b0, 1'b1);
    send_request(CMD_ALLOC, '0, 1'b1, 1'b0);
    send_request(CMD_ALLOC, '0, 1'b1, 1'b1);
    // Entries that already hold a frame are echoed back, the top frame too.
    send_request(CMD_ALLOC, 12'hFFF, 1'b0, 1'b1);
    send_request(CMD_ALLOC, 12'h001, 1'b1, 1'b0);
    // Frame zero means no frame, so freeing it does nothing.
    send_request(CMD_FREE, '0, 1'b1, 1'b1);
    // The top frame was never handed out: freeing it just clears the bit again.
    send_request(CMD_FREE, 12'hFFF, 1'b0, 1'b0);
    send_request(CMD_FREE, 12'h001, 1'b0, 1'b1);
    send_request(CMD_FREE, 12'h001, 1'b1, 1'b0);
    // The freed frame 1 is the lowest clear one again.
    send_request(CMD_ALLOC, '0, 1'b0, 1'b0);
    send_request(CMD_FREE, 12'h800, 1'b0, 1'b0);
    wait_drained();

    // A limit below one word leaves nothing to search.
    write_limit(13'd16);
    send_request(CMD_ALLOC, '0, 1'b0, 1'b1);
    wait_drained();

    // The largest limit is clamped to the bitmap; frame 3 is next.
    write_limit(13'd8191);
    send_request(CMD_ALLOC, '0, 1'b1, 1'b1);
    wait_drained();

    // Random phases, each at its own limit and only after the block drained.
    // The second phase asks for the long hold-off while requests keep coming;
    // two phases run with no gaps on either side.
    for (int p = 0; p < NumPhases; p++) begin
      write_limit(phase_limit[p]);
      quiet = (p == 3 || p == 6);
      if (p == 1) long_hold = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        random_request(phase_limit[p]);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("frame_bitmap_allocator_unit_tb: clean");
    end else begin
      $display("frame_bitmap_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule
